[rtl/qgi_pkg.sv]
// qgi_pkg: shared codes and types of the quadrilinear grid interpolator
// no dependencies; used by the channel interfaces, the mac unit and the core
`default_nettype none

package qgi_pkg;

  // operation codes of an input item
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_INTERP = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_INTERP_DONE = 2'd0,
    STATUS_WRITE_DONE  = 2'd1,
    STATUS_RANGE_ERR   = 2'd2
  } status_t;

  localparam int NUM_AXES    = 4;
  localparam int NUM_CORNERS = 16;
  localparam int PAIR_SLOTS  = 4;

  // what a product in flight through the shared multiplier is for
  typedef enum logic [1:0] {
    MK_PAIR_IJ  = 2'd0,
    MK_PAIR_KT  = 2'd1,
    MK_CORNER_W = 2'd2,
    MK_MAC      = 2'd3
  } mul_kind_t;

  typedef logic [3:0] corner_idx_t;

  typedef struct packed {
    logic        valid;
    mul_kind_t   kind;
    corner_idx_t idx;
  } mul_tag_t;

endpackage

`default_nettype wire

[rtl/qgi_if.sv]
// qgi_in_if and qgi_out_if: valid/ready channels of the grid interpolator
// depends on qgi_pkg for the status code type
`default_nettype none

interface qgi_in_if #(
  parameter int CW = 3,
  parameter int FW = 17,
  parameter int VW = 32
) ();
  import qgi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [CW-1:0]        coord_i;
  logic [CW-1:0]        coord_j;
  logic [CW-1:0]        coord_k;
  logic [CW-1:0]        coord_t;
  logic [FW-1:0]        frac_i;
  logic [FW-1:0]        frac_j;
  logic [FW-1:0]        frac_k;
  logic [FW-1:0]        frac_t;
  logic signed [VW-1:0] write_value;

  modport source (
    output valid, operation, coord_i, coord_j, coord_k, coord_t,
    output frac_i, frac_j, frac_k, frac_t, write_value,
    input  ready
  );

  modport sink (
    input  valid, operation, coord_i, coord_j, coord_k, coord_t,
    input  frac_i, frac_j, frac_k, frac_t, write_value,
    output ready
  );
endinterface

interface qgi_out_if #(
  parameter int VW = 32
) ();
  import qgi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] interp_value;
  status_t              status;

  modport source (
    output valid, interp_value, status,
    input  ready
  );

  modport sink (
    input  valid, interp_value, status,
    output ready
  );
endinterface

`default_nettype wire

[rtl/qgi_mac_unit.sv]
// qgi_mac_unit: shared signed multiplier with a tag pipeline and the accumulator
// depends on qgi_pkg for the product tag
`default_nettype none

module qgi_mac_unit #(
  parameter int AW  = 32,
  parameter int BW  = 18,
  parameter int ACW = 53
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire qgi_pkg::mul_tag_t       req,
  input  wire logic signed [AW-1:0]    op_a,
  input  wire logic signed [BW-1:0]    op_b,
  input  wire logic                    acc_clr,
  output      logic signed [AW+BW-1:0] prod_r,
  output      qgi_pkg::mul_tag_t       tag_r,
  output      logic signed [ACW-1:0]   acc_r
);
  import qgi_pkg::*;

  logic signed [ACW-1:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (acc_clr) begin
      acc_nxt = '0;
    end else if (tag_r.valid && tag_r.kind == MK_MAC) begin
      acc_nxt = acc_r + ACW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= req;
    end
  end

endmodule

`default_nettype wire

[rtl/quadrilinear_grid_interpolator_core.sv]
// sequence: a write item or an out-of-range item goes from acceptance straight to the result
// state; an interpolate item first runs 8 pair weights, 16 corner weights, 17 read/mac slots,
// drain and round, all through one shared multiplier and one single-port grid memory
// throughput: one item at a time, next item taken the cycle after the result is loaded
// reset: synchronous active low, clears the sequencer and output valid; the grid memory
// is not cleared and an entry reads back meaningfully only once written
`default_nettype none

module quadrilinear_grid_interpolator_core #(
  parameter int AXIS_SIZE  = 8,
  parameter int VALUE_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  qgi_in_if.sink     in_chan,
  qgi_out_if.source  out_chan
);
  import qgi_pkg::*;

  // widths
  localparam int CW        = $clog2(AXIS_SIZE);
  localparam int FW        = FRAC_BITS + 1;
  localparam int AW        = (VALUE_BITS > FRAC_BITS + 2) ? VALUE_BITS : FRAC_BITS + 2;
  localparam int BW        = FW + 1;
  localparam int PW        = AW + BW;
  localparam int ACW       = VALUE_BITS + FRAC_BITS + 5;
  localparam int ADDR_W    = 4 * CW;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int STEP_W    = 5;

  localparam logic [CW:0]          AXIS_LIM = (CW + 1)'(AXIS_SIZE);
  localparam logic [FW-1:0]        FRAC_ONE = FW'(1) << FRAC_BITS;
  localparam logic [2*FRAC_BITS:0] WGT_HALF = (2 * FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [ACW-1:0]       ACC_HALF = ACW'(1) << (FRAC_BITS - 1);

  localparam logic [STEP_W-1:0] PAIR_LAST = STEP_W'(2 * PAIR_SLOTS - 1);
  localparam logic [STEP_W-1:0] CWT_LAST  = STEP_W'(NUM_CORNERS - 1);
  localparam logic [STEP_W-1:0] MAC_LAST  = STEP_W'(NUM_CORNERS);

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PAIR   = 7'b0000010,
    ST_CWT    = 7'b0000100,
    ST_MAC    = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_ROUND  = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  // item registers: base corner and per-axis weights (one minus fraction, fraction)
  logic [CW-1:0]       base_r [NUM_AXES];
  logic [FW-1:0]       wlo_r  [NUM_AXES];
  logic [FW-1:0]       whi_r  [NUM_AXES];

  // rounded weight products: i*j pairs, k*t pairs, and the 16 corner weights
  logic [FW-1:0]       wij_r [PAIR_SLOTS];
  logic [FW-1:0]       wkt_r [PAIR_SLOTS];
  logic [FW-1:0]       cw_r  [NUM_CORNERS];

  // grid memory, single port, registered read
  logic [VALUE_BITS-1:0] grid_mem [MEM_DEPTH];
  logic [VALUE_BITS-1:0] rdata_r;
  logic [ADDR_W-1:0]     wr_addr, rd_addr, mem_addr;
  logic                  mem_we, mem_re;

  // result staging and the output register
  logic signed [VALUE_BITS-1:0] res_value_r;
  status_t                      res_status_r;
  logic                         out_valid_r;
  logic signed [VALUE_BITS-1:0] out_value_r;
  status_t                      out_status_r;

  // input decode
  logic [CW-1:0]       coord_in [NUM_AXES];
  logic [FW-1:0]       frac_in  [NUM_AXES];
  logic [FW-1:0]       frac_sat [NUM_AXES];
  logic [NUM_AXES-1:0] wr_oob, base_oob;
  logic                in_acc, is_interp, range_err;

  // shared multiplier interface
  mul_tag_t               mul_req, mac_tag;
  logic signed [AW-1:0]   op_a;
  logic signed [BW-1:0]   op_b;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACW-1:0]  acc_r;
  logic [2*FRAC_BITS:0]   wgt_sum;
  logic [FW-1:0]          wgt_rnd;

  // final rounding and saturation
  logic signed [ACW-1:0]  acc_rnd, acc_shr;
  logic                   acc_fits;
  logic signed [VALUE_BITS-1:0] sat_value;

  logic [3:0] corner;
  logic [3:0] mac_idx;

  // -------------------------------------------------------------------------
  // input side: only the idle sequencer takes an item
  // -------------------------------------------------------------------------
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_interp     = (in_chan.operation == OP_INTERP);

  always_comb begin
    coord_in[0] = in_chan.coord_i;
    coord_in[1] = in_chan.coord_j;
    coord_in[2] = in_chan.coord_k;
    coord_in[3] = in_chan.coord_t;
    frac_in[0]  = in_chan.frac_i;
    frac_in[1]  = in_chan.frac_j;
    frac_in[2]  = in_chan.frac_k;
    frac_in[3]  = in_chan.frac_t;
    for (int a = 0; a < NUM_AXES; a++) begin
      // a write needs the cell inside the grid, an interpolation also its upper neighbour
      wr_oob[a]   = ({1'b0, coord_in[a]} >= AXIS_LIM);
      base_oob[a] = (({1'b0, coord_in[a]} + (CW + 1)'(1)) >= AXIS_LIM);
      // fractions above one act as one
      frac_sat[a] = (frac_in[a] > FRAC_ONE) ? FRAC_ONE : frac_in[a];
    end
  end

  assign range_err = is_interp ? (|base_oob) : (|wr_oob);

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_acc) begin
          state_nxt = (is_interp && !range_err) ? ST_PAIR : ST_RESULT;
        end
      end
      ST_PAIR: begin
        if (step_r == PAIR_LAST) begin
          state_nxt = ST_CWT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_CWT: begin
        if (step_r == CWT_LAST) begin
          state_nxt = ST_MAC;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_MAC: begin
        if (step_r == MAC_LAST) begin
          state_nxt = ST_DRAIN;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_DRAIN:  state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_RESULT;
      ST_RESULT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // capture the item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        base_r[a] <= coord_in[a];
        whi_r[a]  <= frac_sat[a];
        wlo_r[a]  <= FRAC_ONE - frac_sat[a];
      end
    end
  end

  // -------------------------------------------------------------------------
  // operand selection for the shared multiplier
  //   pair phase:   8 products wi*wj and wk*wt, one per cycle
  //   weight phase: 16 products rnd(wij)*rnd(wkt) give the corner weights
  //   mac phase:    corner value read in the preceding slot, then value*weight
  // -------------------------------------------------------------------------
  assign corner  = step_r[3:0];
  assign mac_idx = step_r[3:0] - 4'd1;

  always_comb begin
    mul_req = '0;
    op_a    = '0;
    op_b    = '0;
    priority case (1'b1)
      (state_r == ST_PAIR): begin
        mul_req.valid = 1'b1;
        mul_req.idx   = {2'b00, step_r[1:0]};
        if (!step_r[2]) begin
          mul_req.kind = MK_PAIR_IJ;
          op_a = AW'($signed({1'b0, step_r[1] ? whi_r[0] : wlo_r[0]}));
          op_b = $signed({1'b0, step_r[0] ? whi_r[1] : wlo_r[1]});
        end else begin
          mul_req.kind = MK_PAIR_KT;
          op_a = AW'($signed({1'b0, step_r[1] ? whi_r[2] : wlo_r[2]}));
          op_b = $signed({1'b0, step_r[0] ? whi_r[3] : wlo_r[3]});
        end
      end
      (state_r == ST_CWT): begin
        // corner bits: i, j select the ij pair, k, t select the kt pair
        mul_req.valid = 1'b1;
        mul_req.kind  = MK_CORNER_W;
        mul_req.idx   = corner;
        op_a = AW'($signed({1'b0, wij_r[corner[3:2]]}));
        op_b = $signed({1'b0, wkt_r[corner[1:0]]});
      end
      (state_r == ST_MAC && step_r != '0): begin
        // rdata_r holds the entry of the previous corner
        mul_req.valid = 1'b1;
        mul_req.kind  = MK_MAC;
        mul_req.idx   = mac_idx;
        op_a = AW'($signed(rdata_r));
        op_b = $signed({1'b0, cw_r[mac_idx]});
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  qgi_mac_unit #(
    .AW  (AW),
    .BW  (BW),
    .ACW (ACW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .op_a    (op_a),
    .op_b    (op_b),
    .acc_clr (in_acc),
    .prod_r  (prod_r),
    .tag_r   (mac_tag),
    .acc_r   (acc_r)
  );

  // weight products are nonnegative and at most one squared: round half up back to Q1.F
  assign wgt_sum = prod_r[2*FRAC_BITS:0] + WGT_HALF;
  assign wgt_rnd = wgt_sum[2*FRAC_BITS:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (mac_tag.valid) begin
      unique case (mac_tag.kind)
        MK_PAIR_IJ:  wij_r[mac_tag.idx[1:0]] <= wgt_rnd;
        MK_PAIR_KT:  wkt_r[mac_tag.idx[1:0]] <= wgt_rnd;
        MK_CORNER_W: cw_r[mac_tag.idx]       <= wgt_rnd;
        MK_MAC:      ;
        default:     ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // grid memory: written on an accepted in-range write, read in the mac phase
  // -------------------------------------------------------------------------
  assign wr_addr = {in_chan.coord_i, in_chan.coord_j, in_chan.coord_k, in_chan.coord_t};
  assign rd_addr = {base_r[0] + CW'(corner[3]), base_r[1] + CW'(corner[2]),
                    base_r[2] + CW'(corner[1]), base_r[3] + CW'(corner[0])};
  assign mem_we   = in_acc && !is_interp && !range_err;
  assign mem_re   = (state_r == ST_MAC) && (step_r != MAC_LAST);
  assign mem_addr = mem_we ? wr_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= in_chan.write_value;
    end else if (mem_re) begin
      rdata_r <= grid_mem[mem_addr];
    end
  end

  // -------------------------------------------------------------------------
  // final sum: round half up by F bits, then saturate to the value range
  // -------------------------------------------------------------------------
  assign acc_rnd  = acc_r + $signed(ACC_HALF);
  assign acc_shr  = acc_rnd >>> FRAC_BITS;
  assign acc_fits = (&acc_shr[ACW-1:VALUE_BITS-1]) || !(|acc_shr[ACW-1:VALUE_BITS-1]);

  always_comb begin
    if (acc_fits) begin
      sat_value = acc_shr[VALUE_BITS-1:0];
    end else if (acc_shr[ACW-1]) begin
      sat_value = {1'b1, {(VALUE_BITS - 1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VALUE_BITS - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      // writes and range errors carry zero; interpolations overwrite at round
      res_value_r <= '0;
      if (range_err) begin
        res_status_r <= STATUS_RANGE_ERR;
      end else if (is_interp) begin
        res_status_r <= STATUS_INTERP_DONE;
      end else begin
        res_status_r <= STATUS_WRITE_DONE;
      end
    end else if (state_r == ST_ROUND) begin
      res_value_r <= sat_value;
    end
  end

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESULT && (!out_valid_r || out_chan.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT && (!out_valid_r || out_chan.ready)) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.interp_value = out_value_r;
  assign out_chan.status       = out_status_r;

`ifndef SYNTHESIS
  // an accepted item starts the weight phase or goes straight to its result
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_PAIR || state_r == ST_RESULT))
    else $error("accepted item did not start its sequence");

  // products reaching the accumulator belong to the mac phase of this item
  a_mac_window: assert property (@(posedge clk) disable iff (!rst_n)
    (mac_tag.valid && mac_tag.kind == MK_MAC) |-> (state_r == ST_MAC || state_r == ST_DRAIN))
    else $error("mac product outside the mac phase");

  // every mac slot after the first issues a product
  a_mac_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC && step_r != '0) |-> (mul_req.valid && mul_req.kind == MK_MAC))
    else $error("mac slot without a product");

  // a pending result waits while the previous one is still held
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && out_valid_r && !out_chan.ready)
      |=> (state_r == ST_RESULT && $stable(out_value_r)))
    else $error("result overwrote a held output");
`endif

endmodule

`default_nettype wire
